[sv/ptcd_pkg.sv]
// ----------------------------------------------------------------------------
// ptcd_pkg
// Shared constants and register map for the point-to-cone distance block.
// ----------------------------------------------------------------------------
package ptcd_pkg;

  localparam int COORD_WIDTH_DEF = 20;
  localparam int COEF_WIDTH_DEF  = 16;

  localparam int TRIG_W   = 32;
  localparam int TAN_W    = 16;
  localparam int COSP_W   = 15;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 5;
  localparam int REGIDX_W = 3;

  typedef enum logic [REGIDX_W-1:0] {
    REG_APEX_X    = 3'd0,
    REG_APEX_Y    = 3'd1,
    REG_APEX_Z    = 3'd2,
    REG_YAW_TRIG  = 3'd3,
    REG_TILT_TRIG = 3'd4,
    REG_TAN_PHI   = 3'd5,
    REG_COS_PHI   = 3'd6
  } reg_idx_t;

  localparam logic [TRIG_W-1:0] TRIG_RESET = 32'h4000_0000;
  localparam logic [TAN_W-1:0]  TAN_RESET  = 16'd4096;
  localparam logic [COSP_W-1:0] COSP_RESET = 15'd11585;

endpackage

[sv/ptcd_sqrt.sv]
// ----------------------------------------------------------------------------
// ptcd_sqrt
// Pipelined integer square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module ptcd_sqrt #(
  parameter int RW = 30,
  parameter int PW = 29
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [2*RW-1:0] in_rad,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [RW-1:0]   out_root,
  output logic [PW-1:0]   out_pay
);

  localparam int REMW = RW + 2;

  logic [RW-1:0]   v_r;
  logic [RW-1:0]   load;
  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [2*RW-1:0] rad_r  [RW];
  logic [PW-1:0]   pay_r  [RW];

  always_comb begin
    load[RW-1] = !v_r[RW-1] || out_ready;
    for (int k = RW - 2; k >= 0; k--) begin
      load[k] = !v_r[k] || load[k+1];
    end
  end

  assign in_ready = load[0];

  genvar k;
  generate
    for (k = 0; k < RW; k++) begin : g_stage
      logic            pv;
      logic [REMW-1:0] prem;
      logic [RW-1:0]   proot;
      logic [2*RW-1:0] prad;
      logic [PW-1:0]   ppay;
      logic [REMW-1:0] rem_sh;
      logic [REMW-1:0] trial;
      logic            ge;

      if (k == 0) begin : g_first
        assign pv    = in_valid;
        assign prem  = '0;
        assign proot = '0;
        assign prad  = in_rad;
        assign ppay  = in_pay;
      end else begin : g_next
        assign pv    = v_r[k-1];
        assign prem  = rem_r[k-1];
        assign proot = root_r[k-1];
        assign prad  = rad_r[k-1];
        assign ppay  = pay_r[k-1];
      end

      // bring down the next two radicand bits and try root*4+1
      assign rem_sh = {prem[REMW-3:0], prad[2*RW-1:2*RW-2]};
      assign trial  = {proot, 2'b01};
      assign ge     = (rem_sh >= trial);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (load[k]) begin
          v_r[k] <= pv;
        end
      end

      always_ff @(posedge clk) begin
        if (load[k]) begin
          rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
          root_r[k] <= {proot[RW-2:0], ge};
          rad_r[k]  <= {prad[2*RW-3:0], 2'b00};
          pay_r[k]  <= ppay;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_pay   = pay_r[RW-1];

endmodule

[sv/point_to_cone_distance.sv]
// ----------------------------------------------------------------------------
// point_to_cone_distance
// Closest-approach distance of a 3D point to a configured cone, pipelined.
// ----------------------------------------------------------------------------
// Usage: push one point per transfer on the in_ channel (valid/ready); each
// point gives exactly one transfer on the out_ channel, in order, carrying the
// distance in 1/16 mm and a flag set when it was clipped to full scale.
// The cone (apex, yaw and tilt trig pairs, tan and cos of the half angle) sits
// in APB registers at byte offsets 0x00..0x18; write them only while idle.
// The pipeline has seven stages that translate, rotate and square, then
// the square root, which resolves one bit per stage, then four stages
// that form the cone term, scale and saturate.
// Throughput is one point per cycle; a new point enters every cycle the
// pipeline moves.
// Every stage holds a valid bit and advances whenever its successor has room,
// so bubbles are squeezed out and points keep entering while a finished
// result waits in the output register. When the receiver stalls, the pipe
// fills and then in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module point_to_cone_distance #(
  parameter int COORD_WIDTH = ptcd_pkg::COORD_WIDTH_DEF,
  parameter int COEF_WIDTH  = ptcd_pkg::COEF_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptcd_pkg::PADDR_W-1:0]  paddr,
  input  logic [ptcd_pkg::PDATA_W-1:0]  pwdata,
  output logic [ptcd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // input points
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  // results
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH-1:0]        out_cone_distance,
  output logic                          out_saturated
);

  localparam int CW   = COORD_WIDTH;
  localparam int KW   = COEF_WIDTH;
  localparam int F    = KW - 2;           // rotation fraction bits
  localparam int T    = KW - 4;           // tan fraction bits
  localparam int DW   = CW + 1;           // apex difference
  localparam int P1   = DW + KW;          // first rotation products
  localparam int S1   = P1 + 2;           // first rotation sum with rounding
  localparam int X1W  = S1 - F;           // x1, z1
  localparam int P2   = X1W + KW;         // second rotation products
  localparam int S2   = P2 + 2;
  localparam int X2W  = S2 - F;           // x2, y2
  localparam int RW   = X2W + 1;          // root width
  localparam int SQW  = 2 * X2W + 1;      // sum of squares
  localparam int RSW  = RW + T;           // root aligned to tan fraction
  localparam int TYW  = X2W + ptcd_pkg::TAN_W + 1;
  localparam int DDW  = ((RSW + 1) > TYW ? (RSW + 1) : TYW) + 1;
  localparam int PRW  = DDW + ptcd_pkg::COSP_W;
  localparam int SH   = T + F;
  localparam int QW   = PRW - SH;
  localparam int NF   = 7;                // front stages
  localparam int NB   = 4;                // back stages

  localparam logic signed [S1-1:0] RND1 = S1'(1) <<< (F - 1);
  localparam logic signed [S2-1:0] RND2 = S2'(1) <<< (F - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0]                     apex_x_r, apex_y_r, apex_z_r;
  logic [ptcd_pkg::TRIG_W-1:0]       yaw_r, tilt_r;
  logic [ptcd_pkg::TAN_W-1:0]        tan_r;
  logic [ptcd_pkg::COSP_W-1:0]       cosp_r;
  logic                              cfg_wr;
  ptcd_pkg::reg_idx_t                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = ptcd_pkg::reg_idx_t'(paddr[ptcd_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      apex_x_r <= '0;
      apex_y_r <= '0;
      apex_z_r <= '0;
      yaw_r    <= ptcd_pkg::TRIG_RESET;
      tilt_r   <= ptcd_pkg::TRIG_RESET;
      tan_r    <= ptcd_pkg::TAN_RESET;
      cosp_r   <= ptcd_pkg::COSP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ptcd_pkg::REG_APEX_X:    apex_x_r <= pwdata[CW-1:0];
        ptcd_pkg::REG_APEX_Y:    apex_y_r <= pwdata[CW-1:0];
        ptcd_pkg::REG_APEX_Z:    apex_z_r <= pwdata[CW-1:0];
        ptcd_pkg::REG_YAW_TRIG:  yaw_r    <= pwdata;
        ptcd_pkg::REG_TILT_TRIG: tilt_r   <= pwdata;
        ptcd_pkg::REG_TAN_PHI:   tan_r    <= pwdata[ptcd_pkg::TAN_W-1:0];
        ptcd_pkg::REG_COS_PHI:   cosp_r   <= pwdata[ptcd_pkg::COSP_W-1:0];
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      ptcd_pkg::REG_APEX_X:    prdata = ptcd_pkg::PDATA_W'(apex_x_r);
      ptcd_pkg::REG_APEX_Y:    prdata = ptcd_pkg::PDATA_W'(apex_y_r);
      ptcd_pkg::REG_APEX_Z:    prdata = ptcd_pkg::PDATA_W'(apex_z_r);
      ptcd_pkg::REG_YAW_TRIG:  prdata = yaw_r;
      ptcd_pkg::REG_TILT_TRIG: prdata = tilt_r;
      ptcd_pkg::REG_TAN_PHI:   prdata = ptcd_pkg::PDATA_W'(tan_r);
      ptcd_pkg::REG_COS_PHI:   prdata = ptcd_pkg::PDATA_W'(cosp_r);
      default:                 prdata = '0;
    endcase
  end

  // Trig pairs: cos in the upper field, sin in the lower, each KW bits signed.
  logic [63:0]            yaw_ext, tilt_ext;
  logic signed [KW-1:0]   c1, s1, ca, sa;

  assign yaw_ext  = {32'd0, yaw_r};
  assign tilt_ext = {32'd0, tilt_r};
  assign c1 = $signed(yaw_ext[2*KW-1:KW]);
  assign s1 = $signed(yaw_ext[KW-1:0]);
  assign ca = $signed(tilt_ext[2*KW-1:KW]);
  assign sa = $signed(tilt_ext[KW-1:0]);

  // --------------------------------------------------------------------------
  // Stage control: each stage loads when it is empty or its successor moves
  // --------------------------------------------------------------------------
  logic [NF-1:0] fv_r, fload;
  logic [NB-1:0] bv_r, bload;
  logic          sq_in_ready, sq_out_valid;

  always_comb begin
    bload[NB-1] = !bv_r[NB-1] || out_ready;
    for (int k = NB - 2; k >= 0; k--) begin
      bload[k] = !bv_r[k] || bload[k+1];
    end
    fload[NF-1] = !fv_r[NF-1] || sq_in_ready;
    for (int k = NF - 2; k >= 0; k--) begin
      fload[k] = !fv_r[k] || fload[k+1];
    end
  end

  assign in_ready = fload[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
      bv_r <= '0;
    end else begin
      if (fload[0]) begin
        fv_r[0] <= in_valid;
      end
      for (int k = 1; k < NF; k++) begin
        if (fload[k]) begin
          fv_r[k] <= fv_r[k-1];
        end
      end
      if (bload[0]) begin
        bv_r[0] <= sq_out_valid;
      end
      for (int k = 1; k < NB; k++) begin
        if (bload[k]) begin
          bv_r[k] <= bv_r[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Front: translate, rotate about y then z, square
  // --------------------------------------------------------------------------
  logic signed [DW-1:0]  f0_dx_r, f0_dy_r, f0_dz_r;
  logic signed [P1-1:0]  f1_pa_r, f1_pb_r, f1_pc_r, f1_pd_r;
  logic signed [DW-1:0]  f1_dy_r, f2_dy_r;
  logic signed [X1W-1:0] f2_x1_r, f2_z1_r, f3_z1_r, f4_z1_r;
  logic signed [P2-1:0]  f3_qa_r, f3_qb_r, f3_qc_r, f3_qd_r;
  logic signed [X2W-1:0] f4_x2_r, f4_y2_r, f5_y2_r, f6_y2_r;
  logic [2*X2W-1:0]      f5_sx_r;
  logic [2*X1W-1:0]      f5_sz_r;
  logic [SQW-1:0]        f6_sum_r;

  logic signed [S1-1:0]  sum_x1, sum_z1, shf_x1, shf_z1;
  logic signed [S2-1:0]  sum_x2, sum_y2, shf_x2, shf_y2;
  logic [X2W-1:0]        mag_x2;
  logic [X1W-1:0]        mag_z1;

  always_comb begin
    sum_x1 = S1'(f1_pa_r) - S1'(f1_pb_r) + RND1;
    sum_z1 = S1'(f1_pc_r) + S1'(f1_pd_r) + RND1;
    shf_x1 = sum_x1 >>> F;
    shf_z1 = sum_z1 >>> F;
    sum_x2 = S2'(f3_qa_r) - S2'(f3_qb_r) + RND2;
    sum_y2 = S2'(f3_qc_r) + S2'(f3_qd_r) + RND2;
    shf_x2 = sum_x2 >>> F;
    shf_y2 = sum_y2 >>> F;
    mag_x2 = f4_x2_r[X2W-1] ? X2W'(-f4_x2_r) : X2W'(f4_x2_r);
    mag_z1 = f4_z1_r[X1W-1] ? X1W'(-f4_z1_r) : X1W'(f4_z1_r);
  end

  always_ff @(posedge clk) begin
    if (fload[0]) begin
      f0_dx_r <= DW'(in_point_x) - DW'($signed(apex_x_r));
      f0_dy_r <= DW'(in_point_y) - DW'($signed(apex_y_r));
      f0_dz_r <= DW'(in_point_z) - DW'($signed(apex_z_r));
    end
    if (fload[1]) begin
      f1_pa_r <= f0_dx_r * c1;
      f1_pb_r <= f0_dz_r * s1;
      f1_pc_r <= f0_dx_r * s1;
      f1_pd_r <= f0_dz_r * c1;
      f1_dy_r <= f0_dy_r;
    end
    if (fload[2]) begin
      f2_x1_r <= shf_x1[X1W-1:0];
      f2_z1_r <= shf_z1[X1W-1:0];
      f2_dy_r <= f1_dy_r;
    end
    if (fload[3]) begin
      f3_qa_r <= f2_x1_r * ca;
      f3_qb_r <= P2'(f2_dy_r) * P2'(sa);
      f3_qc_r <= f2_x1_r * sa;
      f3_qd_r <= P2'(f2_dy_r) * P2'(ca);
      f3_z1_r <= f2_z1_r;
    end
    if (fload[4]) begin
      f4_x2_r <= shf_x2[X2W-1:0];
      f4_y2_r <= shf_y2[X2W-1:0];
      f4_z1_r <= f3_z1_r;
    end
    if (fload[5]) begin
      f5_sx_r <= mag_x2 * mag_x2;
      f5_sz_r <= mag_z1 * mag_z1;
      f5_y2_r <= f4_y2_r;
    end
    if (fload[6]) begin
      f6_sum_r <= SQW'(f5_sx_r) + SQW'(f5_sz_r);
      f6_y2_r  <= f5_y2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Radial distance: floor square root, y2 rides alongside
  // --------------------------------------------------------------------------
  logic [RW-1:0]  sq_root;
  logic [X2W-1:0] sq_y2;

  ptcd_sqrt #(
    .RW (RW),
    .PW (X2W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fv_r[NF-1]),
    .in_ready  (sq_in_ready),
    .in_rad    ((2*RW)'(f6_sum_r)),
    .in_pay    (f6_y2_r),
    .out_valid (sq_out_valid),
    .out_ready (bload[0]),
    .out_root  (sq_root),
    .out_pay   (sq_y2)
  );

  // --------------------------------------------------------------------------
  // Back: cone term, magnitude, scale by cos_phi, saturate
  // --------------------------------------------------------------------------
  logic [RSW-1:0]        b0_rs_r;
  logic signed [TYW-1:0] b0_ty_r;
  logic [DDW-1:0]        b1_ad_r;
  logic [PRW-1:0]        b2_prod_r;
  logic [CW-1:0]         b3_dist_r;
  logic                  b3_sat_r;

  logic signed [DDW-1:0] diff;
  logic [QW-1:0]         quo;
  logic                  over;

  always_comb begin
    diff = $signed(DDW'(b0_rs_r)) - DDW'(b0_ty_r);
    quo  = b2_prod_r[PRW-1:SH];
    over = |quo[QW-1:CW];
  end

  always_ff @(posedge clk) begin
    if (bload[0]) begin
      b0_rs_r <= {sq_root, {T{1'b0}}};
      b0_ty_r <= TYW'($signed(sq_y2)) * TYW'($signed({1'b0, tan_r}));
    end
    if (bload[1]) begin
      b1_ad_r <= diff[DDW-1] ? DDW'(-diff) : DDW'(diff);
    end
    if (bload[2]) begin
      b2_prod_r <= PRW'(b1_ad_r) * PRW'(cosp_r);
    end
    if (bload[3]) begin
      b3_dist_r <= over ? {CW{1'b1}} : quo[CW-1:0];
      b3_sat_r  <= over;
    end
  end

  assign out_valid         = bv_r[NB-1];
  assign out_cone_distance = b3_dist_r;
  assign out_saturated     = b3_sat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_cone_distance == {CW{1'b1}})
    else $error("saturated result not at full scale");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready == 1'b0)
    else $error("pipeline not empty after reset");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> fv_r[0])
    else $error("accepted point not captured");

  a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r[NF-1] && !sq_in_ready |=> fv_r[NF-1] && $stable(f6_sum_r))
    else $error("front stage lost an item under stall");

  a_hold_back: assert property (@(posedge clk) disable iff (!rst_n)
    sq_out_valid && !bload[0] |=> sq_out_valid && $stable(sq_root))
    else $error("root lost under stall");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for point_to_cone_distance: programmes cone settings
// over APB, streams points under varied back-pressure and checks each
// distance and saturation flag against a fixed-point model kept here.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW       = ptcd_pkg::COORD_WIDTH_DEF;
  localparam int ROT_F    = ptcd_pkg::COEF_WIDTH_DEF - 2;
  localparam int TAN_F    = ptcd_pkg::COEF_WIDTH_DEF - 4;
  localparam int PIPE_LAT = 41;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_t;

  typedef struct packed {
    logic [CW-1:0] len;
    logic          sat;
  } dist_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [ptcd_pkg::PADDR_W-1:0]   paddr = '0;
  logic [ptcd_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [ptcd_pkg::PDATA_W-1:0]   prdata;
  logic                           pready;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] in_point_x = '0;
  logic signed [CW-1:0] in_point_y = '0;
  logic signed [CW-1:0] in_point_z = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CW-1:0]        out_cone_distance;
  logic                 out_saturated;

  // Shadow copies of the cone registers, updated with every APB write.
  logic [CW-1:0]               cone_apex_x, cone_apex_y, cone_apex_z;
  logic [ptcd_pkg::TRIG_W-1:0] cone_yaw, cone_tilt;
  logic [ptcd_pkg::TAN_W-1:0]  cone_tan;
  logic [ptcd_pkg::COSP_W-1:0] cone_cos;

  point_t pending_points[$];
  dist_t  expected_dists[$];
  int     sender_idle_pct = 0;
  int     receiver_stall_pct = 0;
  int     mismatches = 0;

  point_to_cone_distance dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_cone_distance(out_cone_distance), .out_saturated(out_saturated)
  );

  always #4 clk = ~clk;

  // Round half up, then floor by the rotation fraction.
  function automatic longint rot_round(input longint v);
    return (v + (longint'(1) <<< (ROT_F - 1))) >>> ROT_F;
  endfunction

  // Fixed-point distance from a point to the currently programmed cone.
  function automatic dist_t cone_distance_of(input point_t p);
    longint dx, dy, dz, c1, s1, ca, sa, x1, z1, x2, y2, d;
    logic [63:0]  rad_sq, root, trial;
    logic [127:0] scaled;
    dist_t        res;
    dx = longint'(p.x) - longint'($signed(cone_apex_x));
    dy = longint'(p.y) - longint'($signed(cone_apex_y));
    dz = longint'(p.z) - longint'($signed(cone_apex_z));
    c1 = longint'($signed(cone_yaw[31:16]));
    s1 = longint'($signed(cone_yaw[15:0]));
    ca = longint'($signed(cone_tilt[31:16]));
    sa = longint'($signed(cone_tilt[15:0]));
    x1 = rot_round(dx * c1 - dz * s1);
    z1 = rot_round(dx * s1 + dz * c1);
    x2 = rot_round(x1 * ca - dy * sa);
    y2 = rot_round(x1 * sa + dy * ca);
    rad_sq = x2 * x2 + z1 * z1;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= rad_sq) root = trial;
    end
    d = longint'(root << TAN_F) - y2 * longint'(cone_tan);
    if (d < 0) d = -d;
    scaled = (128'(d) * 128'(cone_cos)) >> (TAN_F + ROT_F);
    if (scaled > 128'((1 << CW) - 1)) begin
      res.len = '1;
      res.sat = 1'b1;
    end else begin
      res.len = scaled[CW-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  // APB write: setup cycle, access cycle, then release the bus.
  task automatic reg_write(input ptcd_pkg::reg_idx_t idx, input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ptcd_pkg::PADDR_W'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ptcd_pkg::REG_APEX_X:    cone_apex_x = v[CW-1:0];
      ptcd_pkg::REG_APEX_Y:    cone_apex_y = v[CW-1:0];
      ptcd_pkg::REG_APEX_Z:    cone_apex_z = v[CW-1:0];
      ptcd_pkg::REG_YAW_TRIG:  cone_yaw    = v;
      ptcd_pkg::REG_TILT_TRIG: cone_tilt   = v;
      ptcd_pkg::REG_TAN_PHI:   cone_tan    = v[ptcd_pkg::TAN_W-1:0];
      ptcd_pkg::REG_COS_PHI:   cone_cos    = v[ptcd_pkg::COSP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cone_write(input logic [31:0] ax, ay, az, yaw, tilt, tn, cs);
    reg_write(ptcd_pkg::REG_APEX_X, ax);
    reg_write(ptcd_pkg::REG_APEX_Y, ay);
    reg_write(ptcd_pkg::REG_APEX_Z, az);
    reg_write(ptcd_pkg::REG_YAW_TRIG, yaw);
    reg_write(ptcd_pkg::REG_TILT_TRIG, tilt);
    reg_write(ptcd_pkg::REG_TAN_PHI, tn);
    reg_write(ptcd_pkg::REG_COS_PHI, cs);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    if ($urandom_range(3) == 0) return CW'($signed($urandom_range(4000)) - 2000);
    return CW'($urandom);
  endfunction

  // Drain the pipe, then hold for its depth so no point is still in flight.
  // Sample on the falling edge so the driver's updates have settled.
  task automatic drain();
    do @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_dists.size() != 0);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  // Driver: record each transfer and present the next point, or idle.
  always @(posedge clk) begin
    point_t nxt;
    logic   load;
    if (in_valid && in_ready)
      expected_dists.push_back(cone_distance_of({in_point_x, in_point_y, in_point_z}));
    load = rst_n && (!in_valid || in_ready) && pending_points.size() != 0 &&
           $urandom_range(99) >= sender_idle_pct;
    if (load) begin
      nxt = pending_points.pop_front();
      in_point_x <= nxt.x; in_point_y <= nxt.y; in_point_z <= nxt.z;
      in_valid <= 1'b1;
    end else if (in_valid && in_ready) begin
      in_valid <= 1'b0;
    end
  end

  // Monitor: check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    dist_t want;
    if (out_valid && out_ready) begin
      if (expected_dists.size() == 0) begin
        $display("%0t: unexpected result dist=%0d sat=%0b", $time,
                 out_cone_distance, out_saturated);
        mismatches++;
      end else begin
        want = expected_dists.pop_front();
        if (out_cone_distance !== want.len) begin
          $display("%0t: distance expected %0d actual %0d", $time, want.len,
                   out_cone_distance);
          mismatches++;
        end
        if (out_saturated !== want.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, want.sat,
                   out_saturated);
          mismatches++;
        end
      end
    end
    out_ready <= rst_n && $urandom_range(99) >= receiver_stall_pct;
  end

  initial begin
    int idle_sched[4][2];
    logic signed [CW-1:0] mx, mn;
    idle_sched = '{'{0, 0}, '{50, 0}, '{0, 50}, '{36, 36}};
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    cone_apex_x = '0; cone_apex_y = '0; cone_apex_z = '0;
    cone_yaw = ptcd_pkg::TRIG_RESET; cone_tilt = ptcd_pkg::TRIG_RESET;
    cone_tan = ptcd_pkg::TAN_RESET; cone_cos = ptcd_pkg::COSP_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed points under reset settings: extremes, apex and on-axis
    // cases.
    pending_points.push_back('{'0, '0, '0});
    pending_points.push_back('{mx, mx, mx});
    pending_points.push_back('{mn, mn, mn});
    pending_points.push_back('{mx, mn, mx});
    pending_points.push_back('{mn, mx, mn});
    pending_points.push_back('{'0, mx, '0});
    pending_points.push_back('{'0, mn, '0});
    pending_points.push_back('{mx, '0, '0});
    pending_points.push_back('{'0, '0, mn});
    pending_points.push_back('{CW'(16), CW'(16), '0});
    pending_points.push_back('{-CW'(1), -CW'(1), -CW'(1)});
    pending_points.push_back('{CW'(1), CW'(1), CW'(1)});
    drain();

    // Extreme settings: large apex, full-scale trig, tan at the top, cos at 1.0.
    cone_write(32'h0007_FFFF, 32'hFFF8_0000, 32'h0007_FFFF, 32'h7FFF_7FFF,
               32'h8000_8000, 32'h0000_FFFF, 32'h0000_4000);
    for (int i = 0; i < 6; i++)
      pending_points.push_back('{rand_coord(), rand_coord(), rand_coord()});
    pending_points.push_back('{mn, mn, mn});
    pending_points.push_back('{mx, mx, mx});
    drain();
    cone_write(32'hFFF8_0000, 32'h0, 32'hFFF8_0000, 32'h0, 32'h0,
               32'h0, 32'hFFFF_FFFF);
    pending_points.push_back('{mx, mx, mx});
    pending_points.push_back('{'0, '0, '0});
    pending_points.push_back('{mn, mn, mn});
    drain();

    // Random phases, cycling through the idle patterns.
    for (int ph = 0; ph < 9; ph++) begin
      sender_idle_pct    = idle_sched[ph % 4][0];
      receiver_stall_pct = idle_sched[ph % 4][1];
      if ($urandom_range(1))
        cone_write({$urandom_range(1) ? $urandom : 32'($urandom_range(4000)) - 2000},
                   32'($urandom_range(4000)) - 2000, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      else
        cone_write(32'($urandom_range(2000)), 32'($urandom_range(2000)), 32'd0,
                   {16'($urandom_range(16384)), 16'($urandom_range(8000))},
                   {16'($urandom_range(16384)), 16'($signed(-$urandom_range(8000)))},
                   32'($urandom_range(8192)), 32'($urandom_range(16384)));
      for (int i = 0; i < 150; i++)
        pending_points.push_back('{rand_coord(), rand_coord(), rand_coord()});
      drain();
    end

    if (mismatches == 0 && expected_dists.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
